@@ hdl/value_to_hue_pseudocolor_defines.svh @@
// assertion macros used by the checker file
`ifndef VALUE_TO_HUE_PSEUDOCOLOR_DEFINES_SVH
`define VALUE_TO_HUE_PSEUDOCOLOR_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define VTHP_ASSERT_NOW(name, cond, chk, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define VTHP_ASSERT_NEXT(name, cond, chk, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
    else $error(msg);

`endif

@@ hdl/vthp_pkg.sv @@
package vthp_pkg;

  // normalised position is unsigned Q0.16, one more bit holds 1.0
  localparam int T_BITS = 16;
  localparam int QUOT_BITS = T_BITS + 1;

  // register port geometry
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // register indexes
  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_SATURATION = 2'd2;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd3;

  // reset values, truncated to the configured widths
  localparam int RESET_RANGE_LOW  = 0;
  localparam int RESET_RANGE_HIGH = 32767;
  localparam int RESET_SATURATION = 255;
  localparam int RESET_BRIGHTNESS = 204;

  // hue sectors of the six-sector rule
  localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;

  // per-stage control that travels alongside each word
  typedef struct packed {
    logic valid;
    logic clamped;
  } vthp_ctl_t;

endpackage

@@ hdl/vthp_regs.sv @@
module vthp_regs #(
  parameter int SAMPLE_BITS = 16,
  parameter int COLOR_BITS  = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vthp_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [vthp_pkg::DATA_BITS-1:0]   pwdata,
  output logic [vthp_pkg::DATA_BITS-1:0]   prdata,
  output logic signed [SAMPLE_BITS-1:0]    range_low,
  output logic signed [SAMPLE_BITS-1:0]    range_high,
  output logic [COLOR_BITS-1:0]            saturation,
  output logic [COLOR_BITS-1:0]            brightness
);
  import vthp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign reg_sel = paddr[ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= SAMPLE_BITS'(RESET_RANGE_LOW);
      range_high <= SAMPLE_BITS'(RESET_RANGE_HIGH);
      saturation <= COLOR_BITS'(RESET_SATURATION);
      brightness <= COLOR_BITS'(RESET_BRIGHTNESS);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RANGE_LOW:  range_low  <= pwdata[SAMPLE_BITS-1:0];
        REG_RANGE_HIGH: range_high <= pwdata[SAMPLE_BITS-1:0];
        REG_SATURATION: saturation <= pwdata[COLOR_BITS-1:0];
        REG_BRIGHTNESS: brightness <= pwdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // readback, zero extended
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_RANGE_LOW:  prdata[SAMPLE_BITS-1:0] = range_low;
      REG_RANGE_HIGH: prdata[SAMPLE_BITS-1:0] = range_high;
      REG_SATURATION: prdata[COLOR_BITS-1:0]  = saturation;
      REG_BRIGHTNESS: prdata[COLOR_BITS-1:0]  = brightness;
      default: ;
    endcase
  end

endmodule

@@ hdl/vthp_div_cell.sv @@
module vthp_div_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [SAMPLE_BITS-1:0]          span,
  input  vthp_pkg::vthp_ctl_t             in_ctl,
  input  logic [SAMPLE_BITS:0]            in_part,
  input  logic [vthp_pkg::QUOT_BITS-1:0]  in_quot,
  output vthp_pkg::vthp_ctl_t             out_ctl,
  output logic [SAMPLE_BITS-1:0]          out_rem,
  output logic [vthp_pkg::QUOT_BITS-1:0]  out_quot
);
  import vthp_pkg::*;

  logic                 fits;
  logic [SAMPLE_BITS:0] diff;

  // one restoring step: subtract the span when the partial remainder covers it
  assign diff = in_part - {1'b0, span};
  assign fits = in_part >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= fits ? diff[SAMPLE_BITS-1:0] : in_part[SAMPLE_BITS-1:0];
      out_quot <= {in_quot[QUOT_BITS-2:0], fits};
    end
  end

endmodule

@@ hdl/vthp_hsv.sv @@
module vthp_hsv #(
  parameter int COLOR_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  vthp_pkg::vthp_ctl_t          in_ctl,
  input  logic [vthp_pkg::T_BITS:0]    hue_t,
  input  logic                         zero_span,
  input  logic [COLOR_BITS-1:0]        saturation,
  input  logic [COLOR_BITS-1:0]        brightness,
  output vthp_pkg::vthp_ctl_t          res_ctl,
  output logic [COLOR_BITS-1:0]        res_red,
  output logic [COLOR_BITS-1:0]        res_green,
  output logic [COLOR_BITS-1:0]        res_blue
);
  import vthp_pkg::*;

  localparam int CB      = COLOR_BITS;
  localparam int PIPE    = 6;
  localparam int MT_BITS = CB + T_BITS;
  localparam int LANES   = 3;
  localparam int LANE_P  = 0;
  localparam int LANE_Q  = 1;
  localparam int LANE_U  = 2;

  localparam logic [CB-1:0]         CMAX      = '1;
  localparam logic [T_BITS:0]       T_ONE     = {1'b1, {T_BITS{1'b0}}};
  localparam logic [MT_BITS-1:0]    CMAX_ONE  = {CMAX, {T_BITS{1'b0}}};
  localparam logic [2*CB-1:0]       HALF_MAX  = (2*CB)'(CMAX >> 1);
  localparam logic [MT_BITS+CB-1:0] HALF_DEN  = (MT_BITS+CB)'({CMAX, {(T_BITS-1){1'b0}}});

  vthp_ctl_t ctl_pipe [PIPE];
  logic [2:0] sec_pipe [PIPE];

  logic [T_BITS:0]        hue_w;
  logic [T_BITS-1:0]      frac_s1;
  logic [T_BITS:0]        frac_c;
  logic [MT_BITS-1:0]     sf_s2;
  logic [MT_BITS:0]       sfc_s2;
  logic [2*CB-1:0]        pv_s2;
  logic [MT_BITS-1:0]     dq;
  logic [MT_BITS:0]       du_full;
  logic [MT_BITS+CB-1:0]  nq_s3;
  logic [MT_BITS+CB-1:0]  nu_s3;
  logic [2*CB-1:0]        yp_s3;
  logic [MT_BITS+CB-1:0]  sum_q;
  logic [MT_BITS+CB-1:0]  sum_u;
  logic [2*CB-1:0]        y_s4 [LANES];
  logic [2*CB:0]          est_sum [LANES];
  logic [CB:0]            est_s5 [LANES];
  logic [2*CB-1:0]        y_s5 [LANES];
  logic [2*CB:0]          rem_full [LANES];
  logic [CB:0]            fixed [LANES];
  logic [CB-1:0]          chan_s6 [LANES];

  // control and sector travel with the word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE; i++) ctl_pipe[i] <= '0;
    end else if (en) begin
      ctl_pipe[0] <= in_ctl;
      for (int i = 1; i < PIPE; i++) ctl_pipe[i] <= ctl_pipe[i-1];
    end
  end

  // hue times four: sector from the top bits, fraction below
  assign hue_w = T_ONE - (zero_span ? '0 : hue_t);

  always_ff @(posedge clk) begin
    if (en) begin
      sec_pipe[0] <= hue_w[T_BITS:T_BITS-2];
      for (int i = 1; i < PIPE; i++) sec_pipe[i] <= sec_pipe[i-1];
      frac_s1 <= {hue_w[T_BITS-3:0], 2'b00};
    end
  end

  // saturation times fraction and its complement
  assign frac_c = T_ONE - {1'b0, frac_s1};

  always_ff @(posedge clk) begin
    if (en) begin
      sf_s2  <= {{T_BITS{1'b0}}, saturation} * {{CB{1'b0}}, frac_s1};
      sfc_s2 <= {{(T_BITS+1){1'b0}}, saturation} * {{CB{1'b0}}, frac_c};
      pv_s2  <= {{CB{1'b0}}, brightness} * {{CB{1'b0}}, CMAX - saturation};
    end
  end

  // brightness times the falling and rising ramps
  assign dq      = CMAX_ONE - sf_s2;
  assign du_full = {1'b0, CMAX_ONE} - sfc_s2;

  always_ff @(posedge clk) begin
    if (en) begin
      nq_s3 <= {{CB{1'b0}}, brightness} * {{CB{1'b0}}, dq};
      nu_s3 <= {{CB{1'b0}}, brightness} * {{CB{1'b0}}, du_full[MT_BITS-1:0]};
      yp_s3 <= pv_s2 + HALF_MAX;
    end
  end

  // add half a step and drop the fraction bits
  assign sum_q = nq_s3 + HALF_DEN;
  assign sum_u = nu_s3 + HALF_DEN;

  always_ff @(posedge clk) begin
    if (en) begin
      y_s4[LANE_P] <= yp_s3;
      y_s4[LANE_Q] <= sum_q[MT_BITS+CB-1:T_BITS];
      y_s4[LANE_U] <= sum_u[MT_BITS+CB-1:T_BITS];
    end
  end

  // divide by 2^n-1: first estimate, at most one short
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      est_sum[i] = {1'b0, y_s4[i]} + {{(CB+1){1'b0}}, y_s4[i][2*CB-1:CB]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        est_s5[i] <= est_sum[i][2*CB:CB];
        y_s5[i]   <= y_s4[i];
      end
    end
  end

  // remainder check and one correction
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rem_full[i] = {1'b0, y_s5[i]} + {{CB{1'b0}}, est_s5[i]} - {est_s5[i], {CB{1'b0}}};
      fixed[i]    = est_s5[i] + {{CB{1'b0}}, (rem_full[i][CB:0] >= {1'b0, CMAX})};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) chan_s6[i] <= fixed[i][CB-1:0];
    end
  end

  // sector selection, grey when unsaturated
  always_comb begin
    if (saturation == '0) begin
      res_red   = brightness;
      res_green = brightness;
      res_blue  = brightness;
    end else begin
      case (sec_pipe[PIPE-1])
        SEC_RED_YELLOW: begin
          res_red = brightness; res_green = chan_s6[LANE_U]; res_blue = chan_s6[LANE_P];
        end
        SEC_YELLOW_GREEN: begin
          res_red = chan_s6[LANE_Q]; res_green = brightness; res_blue = chan_s6[LANE_P];
        end
        SEC_GREEN_CYAN: begin
          res_red = chan_s6[LANE_P]; res_green = brightness; res_blue = chan_s6[LANE_U];
        end
        SEC_CYAN_BLUE: begin
          res_red = chan_s6[LANE_P]; res_green = chan_s6[LANE_Q]; res_blue = brightness;
        end
        SEC_BLUE_MAGENTA: begin
          res_red = chan_s6[LANE_U]; res_green = chan_s6[LANE_P]; res_blue = brightness;
        end
        default: begin
          res_red = brightness; res_green = chan_s6[LANE_P]; res_blue = chan_s6[LANE_Q];
        end
      endcase
    end
  end

  assign res_ctl = ctl_pipe[PIPE-1];

endmodule

@@ hdl/value_to_hue_pseudocolor.sv @@
// False-colour map for a stream of signed samples: each sample is clamped to
// [range_low, range_high] (an inverted range collapses to range_low), placed on
// the scale as a Q0.16 fraction and turned into red, green and blue through a
// hue sweep from blue at range_low to red at range_high, with the configured
// saturation and brightness; clamped flags samples that lay outside the range.
// One sample is taken every clock unless the input stalls. A word passes an
// input register, a row of 17 divider cells that each settle one quotient bit
// of the scale position, six colour stages and the output register. A skid
// register behind the output holds one extra word, and the input stalls only
// while that register is occupied. Registers must be written by the user via
// the APB port while no sample is in flight; the block does not enforce it.
module value_to_hue_pseudocolor #(
  parameter int SAMPLE_BITS = 16,
  parameter int COLOR_BITS  = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vthp_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [vthp_pkg::DATA_BITS-1:0]   pwdata,
  output logic [vthp_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  output logic                             color_valid,
  input  logic                             color_stall,
  output logic [COLOR_BITS-1:0]            red,
  output logic [COLOR_BITS-1:0]            green,
  output logic [COLOR_BITS-1:0]            blue,
  output logic                             clamped
);
  import vthp_pkg::*;

  logic signed [SAMPLE_BITS-1:0] range_low;
  logic signed [SAMPLE_BITS-1:0] range_high;
  logic [COLOR_BITS-1:0]         saturation;
  logic [COLOR_BITS-1:0]         brightness;

  logic                          en;
  logic signed [SAMPLE_BITS-1:0] hi_eff;
  logic signed [SAMPLE_BITS-1:0] x_clamp;
  logic                          below;
  logic                          above;
  logic [SAMPLE_BITS-1:0]        span;
  logic                          zero_span;
  vthp_ctl_t                     ctl0;
  logic [SAMPLE_BITS-1:0]        off0;

  vthp_ctl_t                     cell_ctl  [QUOT_BITS+1];
  logic [SAMPLE_BITS-1:0]        cell_rem  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0]          cell_quot [QUOT_BITS+1];

  vthp_ctl_t                     res_ctl;
  logic [COLOR_BITS-1:0]         res_red;
  logic [COLOR_BITS-1:0]         res_green;
  logic [COLOR_BITS-1:0]         res_blue;

  logic                          skid_valid;
  logic [COLOR_BITS-1:0]         skid_red;
  logic [COLOR_BITS-1:0]         skid_green;
  logic [COLOR_BITS-1:0]         skid_blue;
  logic                          skid_clamped;

  assign pready = 1'b1;

  vthp_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COLOR_BITS  (COLOR_BITS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .range_low  (range_low),
    .range_high (range_high),
    .saturation (saturation),
    .brightness (brightness)
  );

  // whole pipeline moves unless the skid register holds a word
  assign en           = !skid_valid;
  assign sample_stall = skid_valid;

  // clamp to the range, an inverted range collapses onto its low end
  assign hi_eff  = (range_high < range_low) ? range_low : range_high;
  assign below   = sample < range_low;
  assign above   = sample > hi_eff;
  assign x_clamp = below ? range_low : (above ? hi_eff : sample);

  // span of the scale, steady only while the range registers stay unwritten
  always_ff @(posedge clk) begin
    span      <= hi_eff - range_low;
    zero_span <= (hi_eff == range_low);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
    end else if (en) begin
      ctl0 <= '{valid: sample_valid, clamped: below || above};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off0 <= x_clamp - range_low;
    end
  end

  assign cell_ctl[0]  = ctl0;
  assign cell_rem[0]  = off0;
  assign cell_quot[0] = '0;

  // divider row, first cell compares the offset itself, later ones shift
  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
    logic [SAMPLE_BITS:0] part;
    if (i == 0) begin : g_first
      assign part = {1'b0, cell_rem[i]};
    end else begin : g_next
      assign part = {cell_rem[i], 1'b0};
    end

    vthp_div_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .span     (span),
      .in_ctl   (cell_ctl[i]),
      .in_part  (part),
      .in_quot  (cell_quot[i]),
      .out_ctl  (cell_ctl[i+1]),
      .out_rem  (cell_rem[i+1]),
      .out_quot (cell_quot[i+1])
    );
  end

  vthp_hsv #(
    .COLOR_BITS (COLOR_BITS)
  ) u_hsv (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_ctl     (cell_ctl[QUOT_BITS]),
    .hue_t      (cell_quot[QUOT_BITS]),
    .zero_span  (zero_span),
    .saturation (saturation),
    .brightness (brightness),
    .res_ctl    (res_ctl),
    .res_red    (res_red),
    .res_green  (res_green),
    .res_blue   (res_blue)
  );

  // output register with skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (!color_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (!color_valid || !color_stall) begin
      color_valid <= res_ctl.valid;
    end else if (res_ctl.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!color_stall) begin
        red     <= skid_red;
        green   <= skid_green;
        blue    <= skid_blue;
        clamped <= skid_clamped;
      end
    end else if (!color_valid || !color_stall) begin
      red     <= res_red;
      green   <= res_green;
      blue    <= res_blue;
      clamped <= res_ctl.clamped;
    end else if (res_ctl.valid) begin
      skid_red     <= res_red;
      skid_green   <= res_green;
      skid_blue    <= res_blue;
      skid_clamped <= res_ctl.clamped;
    end
  end

endmodule

@@ hdl/vthp_checker.sv @@
`include "value_to_hue_pseudocolor_defines.svh"

module vthp_checker #(
  parameter int COLOR_BITS = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  sample_stall,
  input logic                  color_valid,
  input logic                  color_stall,
  input logic [COLOR_BITS-1:0] red,
  input logic [COLOR_BITS-1:0] green,
  input logic [COLOR_BITS-1:0] blue,
  input logic                  clamped
);

  logic                  stalled;
  logic [3*COLOR_BITS:0] word;

  // output word offered but held back, and its contents
  assign stalled = color_valid && color_stall;
  assign word    = {red, green, blue, clamped};

  // a stalled word stays offered
  `VTHP_ASSERT_NEXT(a_word_held, stalled, color_valid, "stalled word withdrawn")

  // a stalled word keeps its contents
  `VTHP_ASSERT_NEXT(a_word_stable, stalled, $stable(word), "stalled word changed")

  // input stalls only while a word sits at the output
  `VTHP_ASSERT_NOW(a_stall_has_word, sample_stall, color_valid, "input stalled with output empty")

  // input stall starts only after the output was blocked
  `VTHP_ASSERT_NOW(a_stall_cause, $rose(sample_stall), $past(stalled), "stall without back-pressure")

endmodule

bind value_to_hue_pseudocolor vthp_checker #(
  .COLOR_BITS (COLOR_BITS)
) u_vthp_checker (.*);
